>>> sv/spa_pkg.sv
// spa_pkg: shared types and constants for the segregated pool allocator
// no dependencies
package spa_pkg;

	localparam int NUM_POOLS_C   = 4;
	localparam int MAX_BLOCKS_C  = 256;
	localparam int HEADER_BYTES_C = 16;
	localparam int ADDR_BITS_C   = 23;

	localparam int SIZE_W  = 13;
	localparam int COUNT_W = 9;
	localparam int CMD_W   = 2;
	localparam int REQ_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_INIT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FALLBACK  = 2'd1,
		ST_MISALIGN  = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_SIZE0  = 3'd0,
		REG_SIZE1  = 3'd1,
		REG_SIZE2  = 3'd2,
		REG_SIZE3  = 3'd3,
		REG_COUNT0 = 3'd4,
		REG_COUNT1 = 3'd5,
		REG_COUNT2 = 3'd6,
		REG_COUNT3 = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT_MUL,
		S_INIT_CHK,
		S_INIT_FILL,
		S_ALLOC_SCAN,
		S_ALLOC_RD,
		S_ALLOC_WAIT,
		S_ALLOC_MUL,
		S_FREE_SCAN,
		S_FREE_END,
		S_FREE_DIV,
		S_FREE_PUSH,
		S_OUT
	} state_t;

endpackage

>>> sv/spa_if.sv
// spa_if: valid/ready channel interfaces for the pool allocator
// depends on spa_pkg
interface spa_req_if import spa_pkg::*; #(parameter int ADDR_BITS = ADDR_BITS_C);
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [REQ_W-1:0]     req_size;
	logic [ADDR_BITS-1:0] free_addr;
	modport source (output valid, cmd, req_size, free_addr, input ready);
	modport sink   (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface spa_rsp_if import spa_pkg::*; #(parameter int ADDR_BITS = ADDR_BITS_C);
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [ADDR_BITS-1:0] grant_addr;
	logic [1:0]           pool_index;
	modport source (output valid, status, grant_addr, pool_index, input ready);
	modport sink   (input valid, status, grant_addr, pool_index, output ready);
endinterface

interface spa_cfg_if import spa_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/segregated_pool_allocator.sv
// segregated_pool_allocator: four fixed-size block pools with lifo free stacks
// depends on spa_pkg, spa_if (channels) and spa_ram (free stacks)
//
// usage: req carries one item (cmd, req_size, free_addr); rsp returns one item
// (status, grant_addr, pool_index) for every accepted request. cfg writes the
// eight size/count registers; they are only latched by an init command.
// one request is worked on at a time; req is not ready until its rsp item
// has been taken. the shared adder/multiplier and the free stack ram port set
// the timing:
//   alloc: pool scan (one pool a cycle), ram read, stride multiply
//   free : pool scan with end multiply, then restoring division of the offset
//          by the stride, one quotient bit a cycle
//   init : per pool one multiply and check, then one stack entry written a cycle
// a stalled rsp holds its item; nothing else moves meanwhile.
// reset clears stack tops and latched layout, so every alloc and free reports
// fallback until the first init; the stack ram needs no clearing.
module segregated_pool_allocator import spa_pkg::*; #(
	parameter int NUM_POOLS_P  = NUM_POOLS_C,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_C,
	parameter int HEADER_BYTES = HEADER_BYTES_C,
	parameter int ADDR_BITS    = ADDR_BITS_C
) (
	input  logic   clk,
	input  logic   arst_n,
	spa_cfg_if.sink cfg,
	spa_req_if.sink req,
	spa_rsp_if.source rsp
);
	localparam int BLK_W  = $clog2(MAX_BLOCKS);
	localparam int TOP_W  = BLK_W + 1;
	localparam int PIDX_W = 2;
	localparam int RAM_AW = PIDX_W + BLK_W;
	localparam int STR_W  = SIZE_W + 7;
	localparam int WIDE_W = ADDR_BITS + 2;
	localparam int QB_W   = $clog2(BLK_W + 1);
	localparam logic [WIDE_W-1:0] SPACE = WIDE_W'(1) << ADDR_BITS;
	localparam logic [PIDX_W-1:0] LAST_P = PIDX_W'(NUM_POOLS_P - 1);

	logic [SIZE_W-1:0]    reg_size_q  [4];
	logic [COUNT_W-1:0]   reg_count_q [4];
	logic [SIZE_W-1:0]    lat_size_q  [4];
	logic [TOP_W-1:0]     lat_count_q [4];
	logic [TOP_W-1:0]     top_q       [4];
	logic [ADDR_BITS-1:0] base_q      [4];

	state_t state_q, state_d;
	logic [PIDX_W-1:0]    p_q;
	logic [TOP_W-1:0]     k_q;
	logic [WIDE_W-1:0]    next_q;
	logic [WIDE_W-1:0]    end_q;
	logic [TOP_W-1:0]     cnt_q;
	logic [REQ_W-1:0]     req_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [WIDE_W-1:0]    rem_q;
	logic [BLK_W-1:0]     quo_q;
	logic [QB_W-1:0]      qb_q;
	logic [1:0]           status_q;
	logic [ADDR_BITS-1:0] grant_q;
	logic [PIDX_W-1:0]    pidx_q;
	logic [BLK_W-1:0]     blk_q;

	// shared multiplier: stride times block count or index
	logic [STR_W-1:0]   stride;
	logic [TOP_W-1:0]   mul_b;
	logic [WIDE_W-1:0]  prod;
	logic [TOP_W-1:0]   sat_cnt;
	logic [COUNT_W-1:0] rc;

	logic               ram_we;
	logic [RAM_AW-1:0]  ram_addr;
	logic [BLK_W-1:0]   ram_wdata;
	logic [BLK_W-1:0]   ram_rdata;

	logic [ADDR_BITS-1:0] blk_addr;
	logic [WIDE_W-1:0]    off;
	logic [WIDE_W-1:0]    trial;
	logic [WIDE_W-1:0]    sh_stride;
	logic                 alloc_hit;
	logic                 free_hit;

	assign stride   = STR_W'((state_q == S_INIT_MUL) ? reg_size_q[p_q] : lat_size_q[p_q])
		+ STR_W'(HEADER_BYTES);
	assign rc       = reg_count_q[p_q];
	assign sat_cnt  = (rc > COUNT_W'(MAX_BLOCKS)) ? TOP_W'(MAX_BLOCKS) : TOP_W'(rc);
	assign prod     = WIDE_W'((STR_W + TOP_W)'(stride) * (STR_W + TOP_W)'(mul_b));
	assign blk_addr = addr_q - ADDR_BITS'(HEADER_BYTES);
	assign off      = WIDE_W'(blk_addr) - WIDE_W'(base_q[p_q]);
	assign sh_stride = WIDE_W'(stride) << (qb_q - QB_W'(1));
	assign trial    = rem_q - sh_stride;
	assign alloc_hit = REQ_W'(lat_size_q[p_q]) >= req_q && top_q[p_q] != '0;
	assign free_hit  = lat_count_q[p_q] != '0 && blk_addr >= base_q[p_q] &&
		WIDE_W'(blk_addr) < end_q;

	always_comb begin
		unique case (state_q)
			S_INIT_MUL:  mul_b = sat_cnt;
			S_ALLOC_MUL: mul_b = TOP_W'(blk_q);
			default:     mul_b = lat_count_q[p_q];
		endcase
	end

	spa_ram #(.WIDTH(BLK_W), .DEPTH(4 * MAX_BLOCKS)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign cfg.ready = (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.status = status_q;
	assign rsp.grant_addr = grant_q;
	assign rsp.pool_index = pidx_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = {p_q, BLK_W'(0)};
		ram_wdata = BLK_W'(cnt_q - k_q - TOP_W'(1));
		unique case (state_q)
			S_INIT_FILL: begin
				ram_we   = (k_q < cnt_q);
				ram_addr = {p_q, k_q[BLK_W-1:0]};
			end
			S_ALLOC_RD:  ram_addr = {p_q, top_q[p_q][BLK_W-1:0]};
			S_FREE_PUSH: begin
				ram_we    = 1'b1;
				ram_addr  = {p_q, top_q[p_q][BLK_W-1:0]};
				ram_wdata = quo_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					priority case (req.cmd)
						CMD_INIT:  state_d = S_INIT_MUL;
						CMD_ALLOC: state_d = S_ALLOC_SCAN;
						CMD_FREE:  state_d = (req.free_addr >= ADDR_BITS'(HEADER_BYTES)) ?
							S_FREE_SCAN : S_OUT;
						default:   state_d = S_OUT;
					endcase
				end
			end
			S_INIT_MUL:  state_d = S_INIT_CHK;
			S_INIT_CHK:  state_d = S_INIT_FILL;
			S_INIT_FILL: begin
				if (k_q >= cnt_q) begin
					state_d = (p_q == LAST_P) ? S_OUT : S_INIT_MUL;
				end
			end
			S_ALLOC_SCAN: begin
				if (alloc_hit) begin
					state_d = S_ALLOC_RD;
				end else if (p_q == LAST_P) begin
					state_d = S_OUT;
				end
			end
			S_ALLOC_RD:   state_d = S_ALLOC_WAIT;
			S_ALLOC_WAIT: state_d = S_ALLOC_MUL;
			S_ALLOC_MUL:  state_d = S_OUT;
			S_FREE_SCAN:  state_d = S_FREE_END;
			S_FREE_END: begin
				if (free_hit) begin
					state_d = S_FREE_DIV;
				end else if (p_q == LAST_P) begin
					state_d = S_OUT;
				end else begin
					state_d = S_FREE_SCAN;
				end
			end
			S_FREE_DIV: begin
				if (qb_q == '0) begin
					state_d = (rem_q != '0 || top_q[p_q] >= lat_count_q[p_q]) ?
						S_OUT : S_FREE_PUSH;
				end
			end
			S_FREE_PUSH: state_d = S_OUT;
			S_OUT: if (rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_size_q  <= '{13'd16, 13'd32, 13'd64, 13'd128};
			reg_count_q <= '{9'd64, 9'd64, 9'd64, 9'd64};
			for (int i = 0; i < 4; i++) begin
				lat_size_q[i]  <= '0;
				lat_count_q[i] <= '0;
				top_q[i]       <= '0;
				base_q[i]      <= '0;
			end
			p_q <= '0;
			k_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					p_q <= '0;
					k_q <= '0;
					if (cfg.valid) begin
						if (cfg.index[2]) begin
							reg_count_q[cfg.index[1:0]] <= cfg.data[COUNT_W-1:0];
						end else begin
							reg_size_q[cfg.index[1:0]] <= cfg.data;
						end
					end
					if (req.valid && req.cmd == CMD_INIT) begin
						for (int i = 0; i < 4; i++) begin
							lat_size_q[i]  <= '0;
							lat_count_q[i] <= '0;
							top_q[i]       <= '0;
							base_q[i]      <= '0;
						end
					end
				end
				S_INIT_MUL: begin
					lat_size_q[p_q] <= reg_size_q[p_q];
					k_q <= '0;
				end
				S_INIT_CHK: begin
					if (end_q <= SPACE) begin
						base_q[p_q]      <= next_q[ADDR_BITS-1:0];
						lat_count_q[p_q] <= cnt_q;
						top_q[p_q]       <= cnt_q;
					end
				end
				S_INIT_FILL: begin
					if (k_q >= cnt_q) begin
						p_q <= p_q + PIDX_W'(1);
					end else begin
						k_q <= k_q + TOP_W'(1);
					end
				end
				S_ALLOC_SCAN: begin
					if (alloc_hit) begin
						top_q[p_q] <= top_q[p_q] - TOP_W'(1);
					end else if (p_q != LAST_P) begin
						p_q <= p_q + PIDX_W'(1);
					end
				end
				S_FREE_END: begin
					if (!free_hit && p_q != LAST_P) begin
						p_q <= p_q + PIDX_W'(1);
					end
				end
				S_FREE_PUSH: top_q[p_q] <= top_q[p_q] + TOP_W'(1);
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q    <= req.req_size;
				addr_q   <= req.free_addr;
				next_q   <= '0;
				grant_q  <= '0;
				pidx_q   <= '0;
				status_q <= (req.cmd == CMD_INIT) ? ST_OK : ST_FALLBACK;
			end
			S_INIT_MUL: begin
				cnt_q <= sat_cnt;
				end_q <= next_q + prod;
			end
			S_INIT_CHK: begin
				if (end_q <= SPACE) begin
					next_q <= end_q;
				end else begin
					cnt_q <= '0;
				end
			end
			S_ALLOC_SCAN: if (alloc_hit) pidx_q <= p_q;
			S_ALLOC_MUL: begin
				grant_q  <= ADDR_BITS'(WIDE_W'(base_q[p_q]) + prod + WIDE_W'(HEADER_BYTES));
				status_q <= ST_OK;
			end
			S_FREE_SCAN: end_q <= WIDE_W'(base_q[p_q]) + prod;
			S_FREE_END: begin
				if (free_hit) pidx_q <= p_q;
				rem_q  <= off;
				quo_q  <= '0;
				qb_q   <= QB_W'(BLK_W);
			end
			S_FREE_DIV: begin
				if (qb_q != '0) begin
					qb_q <= qb_q - QB_W'(1);
					if (rem_q >= sh_stride) begin
						rem_q <= trial;
						quo_q <= quo_q | (BLK_W'(1) << (qb_q - QB_W'(1)));
					end
				end else if (rem_q != '0) begin
					status_q <= ST_MISALIGN;
				end else if (top_q[p_q] >= lat_count_q[p_q]) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_OK;
				end
			end
			default: ;
		endcase
		blk_q <= ram_rdata;
	end

`ifndef SYNTH
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.grant_addr))
		else $error("rsp item changed while stalled");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while result pending");
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q[p_q] <= lat_count_q[p_q])
		else $error("stack top above pool count");
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.grant_addr != '0 |-> rsp.status == ST_OK)
		else $error("grant with bad status");
`endif
endmodule

>>> sv/spa_ram.sv
// spa_ram: generic single-port ram with registered read
// no dependencies
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
